// ----- design/e2q_pkg.sv -----
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared types, constants and the CORDIC micro-rotation used by the
// Euler-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package e2q_pkg;

  // CORDIC datapath word: Q2.30 for x and y, 2^32 per turn for z.
  localparam int CORDIC_W = 32;
  localparam int N_STEPS  = 30;

  // Start value of x: the inverse CORDIC gain in Q2.30.
  localparam logic signed [CORDIC_W-1:0] X_INIT = 32'sd652032874;

  // atan(2^-i) in units of 2^32 per turn.
  localparam logic signed [CORDIC_W-1:0] ATAN_TAB [N_STEPS] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81,
    32'sd41,        32'sd20,        32'sd10,        32'sd5,
    32'sd3,         32'sd1
  };

  // One rotator: cosine accumulator, sine accumulator, residual angle.
  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
  } lane_t;

  // The three half-angle rotators that travel together down the chain.
  typedef struct packed {
    lane_t roll;
    lane_t pitch;
    lane_t yaw;
  } row_t;

  // One rotation-mode micro-rotation; shifts are arithmetic (floor).
  function automatic lane_t cordic_step(lane_t a, int unsigned sh,
                                        logic signed [CORDIC_W-1:0] ang);
    lane_t r;
    logic signed [CORDIC_W-1:0] dx;
    logic signed [CORDIC_W-1:0] dy;
    dx = a.y >>> sh;
    dy = a.x >>> sh;
    if (!a.z[CORDIC_W-1]) begin
      r.x = a.x - dx;
      r.y = a.y + dy;
      r.z = a.z - ang;
    end else begin
      r.x = a.x + dx;
      r.y = a.y - dy;
      r.z = a.z + ang;
    end
    return r;
  endfunction

endpackage

// ----- design/e2q_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// e2q_cordic_cell
// One CORDIC step for all three angles, registered, with its valid bit.
// ----------------------------------------------------------------------------
module e2q_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           valid_in,
  input  e2q_pkg::row_t  row_in,
  output logic           valid,
  output e2q_pkg::row_t  row
);
  import e2q_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row.roll  <= cordic_step(row_in.roll,  STEP, ATAN_TAB[STEP]);
      row.pitch <= cordic_step(row_in.pitch, STEP, ATAN_TAB[STEP]);
      row.yaw   <= cordic_step(row_in.yaw,   STEP, ATAN_TAB[STEP]);
    end
  end

endmodule

// ----- design/e2q_quat_math.sv -----
// ----------------------------------------------------------------------------
// e2q_quat_math
// Pair products, rounding, triple products, sums and output saturation,
// in five registered stages.
// ----------------------------------------------------------------------------
module e2q_quat_math #(
  parameter int QUAT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        valid_in,
  input  e2q_pkg::row_t               row_in,
  output logic                        valid,
  output logic signed [QUAT_BITS-1:0] q_w,
  output logic signed [QUAT_BITS-1:0] q_x,
  output logic signed [QUAT_BITS-1:0] q_y,
  output logic signed [QUAT_BITS-1:0] q_z
);
  import e2q_pkg::*;

  localparam int PROD_W = 2 * CORDIC_W;
  localparam int SHIFT  = 61 - QUAT_BITS;
  localparam logic signed [PROD_W-1:0] RND30 = 64'sd1 <<< 29;
  localparam logic signed [PROD_W-1:0] RND   = 64'sd1 <<< (SHIFT - 1);
  localparam logic signed [PROD_W-1:0] QMAX  = (64'sd1 <<< (QUAT_BITS - 1)) - 64'sd1;
  localparam logic signed [PROD_W-1:0] QMIN  = -(64'sd1 <<< (QUAT_BITS - 1));

  logic [4:0] vld;

  // Stage 1: roll/pitch pair products, yaw carried along.
  logic signed [PROD_W-1:0]   p_cc, p_ss, p_sc, p_cs;
  logic signed [CORDIC_W-1:0] cy1, sy1;
  // Stage 2: pairs rounded back to Q30.
  logic signed [CORDIC_W-1:0] r_cc, r_ss, r_sc, r_cs;
  logic signed [CORDIC_W-1:0] cy2, sy2;
  // Stage 3: triple products.
  logic signed [PROD_W-1:0]   t_w1, t_w2, t_x1, t_x2, t_y1, t_y2, t_z1, t_z2;
  // Stage 4: Q60 sums.
  logic signed [PROD_W-1:0]   sum [4];
  // Stage 5: rounded and saturated parts.
  logic signed [QUAT_BITS-1:0] part [4];
  logic signed [QUAT_BITS-1:0] part_next [4];

  logic signed [PROD_W-1:0] rc_cc, rc_ss, rc_sc, rc_cs;
  logic signed [PROD_W-1:0] shifted [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[3:0], valid_in};
    end
  end

  always_comb begin
    rc_cc = p_cc + RND30;
    rc_ss = p_ss + RND30;
    rc_sc = p_sc + RND30;
    rc_cs = p_cs + RND30;
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      shifted[k] = (sum[k] + RND) >>> SHIFT;
      if (shifted[k] > QMAX) begin
        part_next[k] = QMAX[QUAT_BITS-1:0];
      end else if (shifted[k] < QMIN) begin
        part_next[k] = QMIN[QUAT_BITS-1:0];
      end else begin
        part_next[k] = shifted[k][QUAT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_cc <= PROD_W'(row_in.roll.x) * PROD_W'(row_in.pitch.x);
      p_ss <= PROD_W'(row_in.roll.y) * PROD_W'(row_in.pitch.y);
      p_sc <= PROD_W'(row_in.roll.y) * PROD_W'(row_in.pitch.x);
      p_cs <= PROD_W'(row_in.roll.x) * PROD_W'(row_in.pitch.y);
      cy1  <= row_in.yaw.x;
      sy1  <= row_in.yaw.y;

      r_cc <= rc_cc[61:30];
      r_ss <= rc_ss[61:30];
      r_sc <= rc_sc[61:30];
      r_cs <= rc_cs[61:30];
      cy2  <= cy1;
      sy2  <= sy1;

      t_w1 <= PROD_W'(r_cc) * PROD_W'(cy2);
      t_w2 <= PROD_W'(r_ss) * PROD_W'(sy2);
      t_x1 <= PROD_W'(r_sc) * PROD_W'(cy2);
      t_x2 <= PROD_W'(r_cs) * PROD_W'(sy2);
      t_y1 <= PROD_W'(r_cs) * PROD_W'(cy2);
      t_y2 <= PROD_W'(r_sc) * PROD_W'(sy2);
      t_z1 <= PROD_W'(r_cc) * PROD_W'(sy2);
      t_z2 <= PROD_W'(r_ss) * PROD_W'(cy2);

      sum[0] <= t_w1 + t_w2;
      sum[1] <= t_x1 - t_x2;
      sum[2] <= t_y1 + t_y2;
      sum[3] <= t_z1 - t_z2;

      part <= part_next;
    end
  end

  assign valid = vld[4];
  assign q_w   = part[0];
  assign q_x   = part[1];
  assign q_y   = part[2];
  assign q_z   = part[3];

endmodule

// ----- design/euler_to_quaternion.sv -----
// ----------------------------------------------------------------------------
// euler_to_quaternion
// An accepted input beat is registered into the first of 30 CORDIC cells;
// 5 multiply/round stages and the output register follow it to out_valid.
// Throughput: one beat per cycle while the skid register is empty; the CORDIC
// chain and the multiplier stages each take a new item every cycle until a
// result parks in the skid register, and they hold while it is there.
// Reset: rst clears every valid bit and the output buffer; no result is shown.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
  parameter int ANGLE_BITS = 16,
  parameter int QUAT_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [ANGLE_BITS-1:0] roll_in,
  input  logic signed [ANGLE_BITS-1:0] pitch_in,
  input  logic signed [ANGLE_BITS-1:0] yaw_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [QUAT_BITS-1:0]  quat_w,
  output logic signed [QUAT_BITS-1:0]  quat_x,
  output logic signed [QUAT_BITS-1:0]  quat_y,
  output logic signed [QUAT_BITS-1:0]  quat_z
);
  import e2q_pkg::*;

  // Each angle is placed at the top of a 32-bit turn word; halving it with
  // the sign kept gives the CORDIC start angle in [-pi/2, pi/2).
  localparam int ASHIFT = CORDIC_W - ANGLE_BITS;

  // The whole pipeline moves together. It only stops once the skid register
  // is occupied, so the chain keeps taking beats while the output register
  // holds a result the consumer has not yet taken.
  logic en;
  logic skid_valid;

  logic [CORDIC_W-1:0] turn_r, turn_p, turn_y;
  row_t                row_head;

  logic  cell_valid [N_STEPS];
  row_t  cell_row   [N_STEPS];

  logic                        m_valid;
  logic signed [QUAT_BITS-1:0] m_w, m_x, m_y, m_z;
  logic signed [QUAT_BITS-1:0] skid_w, skid_x, skid_y, skid_z;
  logic                        push;

  assign en       = !skid_valid;
  assign in_ready = en;

  always_comb begin
    turn_r = CORDIC_W'(unsigned'(roll_in))  << ASHIFT;
    turn_p = CORDIC_W'(unsigned'(pitch_in)) << ASHIFT;
    turn_y = CORDIC_W'(unsigned'(yaw_in))   << ASHIFT;

    row_head.roll.x  = X_INIT;
    row_head.roll.y  = '0;
    row_head.roll.z  = {turn_r[CORDIC_W-1], turn_r[CORDIC_W-1:1]};
    row_head.pitch.x = X_INIT;
    row_head.pitch.y = '0;
    row_head.pitch.z = {turn_p[CORDIC_W-1], turn_p[CORDIC_W-1:1]};
    row_head.yaw.x   = X_INIT;
    row_head.yaw.y   = '0;
    row_head.yaw.z   = {turn_y[CORDIC_W-1], turn_y[CORDIC_W-1:1]};
  end

  // The CORDIC chain: cell i performs micro-rotation i on all three angles
  // and its registered result feeds cell i+1.
  for (genvar i = 0; i < N_STEPS; i++) begin : g_cell
    if (i == 0) begin : g_first
      e2q_cordic_cell #(.STEP(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .valid_in (in_valid),
        .row_in   (row_head),
        .valid    (cell_valid[i]),
        .row      (cell_row[i])
      );
    end else begin : g_rest
      e2q_cordic_cell #(.STEP(i)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .en       (en),
        .valid_in (cell_valid[i-1]),
        .row_in   (cell_row[i-1]),
        .valid    (cell_valid[i]),
        .row      (cell_row[i])
      );
    end
  end

  // After the last cell, x holds the half-angle cosine and y the sine.
  e2q_quat_math #(.QUAT_BITS(QUAT_BITS)) u_math (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .valid_in (cell_valid[N_STEPS-1]),
    .row_in   (cell_row[N_STEPS-1]),
    .valid    (m_valid),
    .q_w      (m_w),
    .q_x      (m_x),
    .q_y      (m_y),
    .q_z      (m_z)
  );

  // Output register with a one-entry skid stage behind it. A result that
  // arrives while the output beat is stalled parks in the skid register,
  // and the pipeline halts for as long as it is there.
  assign push = en && m_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_ready) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_ready) begin
        quat_w <= skid_w;
        quat_x <= skid_x;
        quat_y <= skid_y;
        quat_z <= skid_z;
      end
    end else if (push) begin
      if (out_valid && !out_ready) begin
        skid_w <= m_w;
        skid_x <= m_x;
        skid_y <= m_y;
        skid_z <= m_z;
      end else begin
        quat_w <= m_w;
        quat_x <= m_x;
        quat_y <= m_y;
        quat_z <= m_z;
      end
    end
  end

  // The skid register is only ever filled behind a waiting output beat.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result with no output beat in front");

  // A parked result stays parked until the consumer takes the output beat.
  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !out_ready) |=> skid_valid)
    else $error("skid register emptied while the output was stalled");

  // A result reaching a stalled, occupied output must go into the skid stage.
  a_skid_catches: assert property (@(posedge clk) disable iff (rst)
    (m_valid && en && out_valid && !out_ready) |=> skid_valid)
    else $error("result arriving at a stalled output was not parked");

  // Nothing is presented in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> (!out_valid && !skid_valid))
    else $error("output buffer not cleared by reset");

endmodule
